// ===== hdl/dtdm_pkg.sv =====
// Shared types, constants and register codes of the dual timebase drift monitor.
package dtdm_pkg;

  localparam int RING_DEPTH_DEF  = 16;
  localparam int QUEUE_DEPTH_DEF = 2;
  localparam int MAX_REPLAY      = 16;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int SECS_W     = 23;

  localparam logic [CFG_IDX_W-1:0] REG_DRIFT_EVENT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LAG_MIN     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LAG_MAX     = 2'd2;

  localparam logic [CFG_DATA_W-1:0] DRIFT_EVENT_RESET = 16'd50;
  localparam logic [CFG_DATA_W-1:0] LAG_MIN_RESET     = 16'd20;
  localparam logic [CFG_DATA_W-1:0] LAG_MAX_RESET     = 16'd400;

  // floor(x / 1000) = (x * DIV1000_MUL) >> DIV1000_SHIFT for any 32-bit x
  localparam logic [28:0] DIV1000_MUL   = 29'd274877907;
  localparam int          DIV1000_SHIFT = 38;

  localparam logic [5:0] FL_NONE    = 6'h00;
  localparam logic [5:0] FL_LOGGED  = 6'h01;
  localparam logic [5:0] FL_DRIFT   = 6'h02;
  localparam logic [5:0] FL_LAG     = 6'h04;
  localparam logic [5:0] FL_JUMP    = 6'h08;
  localparam logic [5:0] FL_SEED    = 6'h10;
  localparam logic [5:0] FL_VALID   = 6'h20;

  typedef enum logic {
    OP_SAMPLE  = 1'b0,
    OP_READOUT = 1'b1
  } op_t;

  typedef struct packed {
    logic        cmd;
    logic [31:0] tick_count_ms;
    logic [31:0] timer_count_ms;
    logic [31:0] mono_time_ms;
  } in_item_t;

  typedef struct packed {
    op_t         op;
    logic [31:0] tick;
    logic [31:0] timer;
    logic [31:0] mono;
  } work_t;

  typedef struct packed {
    logic [5:0]         event_flags;
    logic signed [31:0] drift_sum_ms;
    logic [31:0]        drift_event_count;
    logic [31:0]        lag_event_count;
    logic [15:0]        stall_max_out_ms;
    logic [31:0]        jump_event_count;
    logic signed [31:0] last_drift_out_ms;
    logic [SECS_W-1:0]  last_drift_time_s;
    logic signed [31:0] raw_tick_delta;
    logic signed [31:0] raw_timer_delta;
    logic               last;
  } res_item_t;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] drift_event_ms;
    logic [CFG_DATA_W-1:0] lag_min_ms;
    logic [CFG_DATA_W-1:0] lag_max_ms;
  } cfg_t;

endpackage

// ===== hdl/dtdm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module dtdm_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/dtdm_fifo.sv =====
// Small register-based FIFO used for the work queue and the result queue.
module dtdm_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== hdl/dtdm_front.sv =====
// Front end: accepts input items into the work queue and decodes the command.
module dtdm_front #(
  parameter int QUEUE_DEPTH = dtdm_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  dtdm_pkg::in_item_t in_item,
  output logic               full,
  output dtdm_pkg::work_t    work,
  output logic               work_valid,
  input  logic               work_pop
);

  dtdm_pkg::in_item_t head;
  logic               q_empty;

  dtdm_fifo #(
    .WIDTH ($bits(dtdm_pkg::in_item_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (in_item),
    .full  (full),
    .pop   (work_pop),
    .dout  (head),
    .empty (q_empty)
  );

  assign work_valid = !q_empty;

  always_comb begin
    work.op    = dtdm_pkg::op_t'(head.cmd);
    work.tick  = head.tick_count_ms;
    work.timer = head.timer_count_ms;
    work.mono  = head.mono_time_ms;
  end

endmodule

// ===== hdl/dtdm_back.sv =====
// Back end: runs samples and ring readouts, holds the monitor state and the ring.
module dtdm_back #(
  parameter int RING_DEPTH = dtdm_pkg::RING_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  dtdm_pkg::cfg_t      cfg,
  input  dtdm_pkg::work_t     work,
  input  logic                work_valid,
  output logic                work_pop,
  output dtdm_pkg::res_item_t res,
  output logic                res_push,
  input  logic                res_full
);

  localparam int IDX_W  = $clog2(RING_DEPTH);
  localparam int FILL_W = $clog2(RING_DEPTH + 1);
  localparam int CNT_W  = $clog2(dtdm_pkg::MAX_REPLAY + 1);
  localparam int NW     = (FILL_W > CNT_W) ? FILL_W : CNT_W;
  localparam int PW     = IDX_W + 2;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_DIFF  = 7'b0000010,
    S_CLASS = 7'b0000100,
    S_EVAL  = 7'b0001000,
    S_READ  = 7'b0010000,
    S_RDATA = 7'b0100000,
    S_EMIT  = 7'b1000000
  } state_t;

  state_t state;

  logic        seeded;
  logic [31:0] prev_tick;
  logic [31:0] prev_timer;
  logic [31:0] drift_sum;
  logic [31:0] last_drift;
  logic [dtdm_pkg::SECS_W-1:0] last_drift_secs;
  logic [31:0] drift_events;
  logic [31:0] lag_events;
  logic [15:0] peak_lag;
  logic [31:0] jump_events;
  logic [IDX_W-1:0]  wr_idx;
  logic [FILL_W-1:0] fill;

  logic [31:0] d_tick;
  logic [31:0] d_timer;
  logic [31:0] diff;
  logic [31:0] mono;
  logic [60:0] prod;
  logic [5:0]  flags;
  logic        res_last;
  logic [IDX_W-1:0] rd_ptr;
  logic [CNT_W-1:0] rd_left;

  logic [63:0] ram_rdata;
  logic        ram_we;
  logic        ram_re;

  logic [31:0]        lag;
  logic [15:0]        lag_lo;
  logic signed [32:0] sd;
  logic signed [32:0] sl;
  logic signed [32:0] hp;
  logic signed [32:0] tp;
  logic signed [32:0] lmin;
  logic signed [32:0] lmax;
  logic               dt_ok;
  logic               f_log;
  logic               f_drift;
  logic               f_lag;
  logic               f_jump;

  logic [NW-1:0]    fill_ext;
  logic [CNT_W-1:0] n_sel;
  logic [PW-1:0]    start_sum;
  logic [IDX_W-1:0] start_ptr;

  dtdm_ram #(
    .WIDTH (64),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_idx),
    .wdata ({d_tick, d_timer}),
    .re    (ram_re),
    .raddr (rd_ptr),
    .rdata (ram_rdata)
  );

  assign ram_we   = (state == S_EVAL) && flags[0];
  assign ram_re   = (state == S_READ);
  assign work_pop = (state == S_IDLE) && work_valid;
  assign res_push = (state == S_EMIT) && !res_full;

  always_comb begin
    lag    = 32'd0 - diff;
    lag_lo = lag[15:0];
    sd     = {diff[31], diff};
    sl     = {lag[31], lag};
    hp     = {18'd0, cfg.drift_event_ms[15:1]};
    tp     = {17'd0, cfg.drift_event_ms};
    lmin   = {17'd0, cfg.lag_min_ms};
    lmax   = {17'd0, cfg.lag_max_ms};
    dt_ok  = !d_tick[31] && !d_timer[31] && (d_timer != 32'd0);
    f_log   = (sd > hp) || (sd < -hp);
    f_drift = (sd > tp) || (sd < -tp);
    f_lag   = dt_ok && (sl >= lmin) && (sl <= lmax);
    f_jump  = dt_ok && !f_lag && (sl > lmax);
  end

  always_comb begin
    fill_ext  = NW'(fill);
    n_sel     = (fill_ext > NW'(dtdm_pkg::MAX_REPLAY)) ? CNT_W'(dtdm_pkg::MAX_REPLAY)
                                                        : CNT_W'(fill_ext);
    start_sum = PW'(wr_idx) + PW'(RING_DEPTH) - PW'(n_sel);
    start_ptr = (start_sum >= PW'(RING_DEPTH)) ? IDX_W'(start_sum - PW'(RING_DEPTH))
                                               : IDX_W'(start_sum);
  end

  always_comb begin
    res.event_flags       = flags;
    res.drift_sum_ms      = drift_sum;
    res.drift_event_count = drift_events;
    res.lag_event_count   = lag_events;
    res.stall_max_out_ms  = peak_lag;
    res.jump_event_count  = jump_events;
    res.last_drift_out_ms = last_drift;
    res.last_drift_time_s = last_drift_secs;
    res.raw_tick_delta    = d_tick;
    res.raw_timer_delta   = d_timer;
    res.last              = res_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      seeded          <= 1'b0;
      prev_tick       <= '0;
      prev_timer      <= '0;
      drift_sum       <= '0;
      last_drift      <= '0;
      last_drift_secs <= '0;
      drift_events    <= '0;
      lag_events      <= '0;
      peak_lag        <= '0;
      jump_events     <= '0;
      wr_idx          <= '0;
      fill            <= '0;
      rd_left         <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (work_valid) begin
            if (work.op == dtdm_pkg::OP_SAMPLE) begin
              prev_tick  <= work.tick;
              prev_timer <= work.timer;
              mono       <= work.mono;
              res_last   <= 1'b1;
              if (!seeded) begin
                seeded  <= 1'b1;
                d_tick  <= '0;
                d_timer <= '0;
                flags   <= dtdm_pkg::FL_SEED;
                state   <= S_EMIT;
              end else begin
                d_tick  <= work.tick - prev_tick;
                d_timer <= work.timer - prev_timer;
                state   <= S_DIFF;
              end
            end else if (n_sel == '0) begin
              d_tick   <= '0;
              d_timer  <= '0;
              flags    <= dtdm_pkg::FL_NONE;
              res_last <= 1'b1;
              state    <= S_EMIT;
            end else begin
              rd_left <= n_sel;
              rd_ptr  <= start_ptr;
              state   <= S_READ;
            end
          end
        end
        S_DIFF: begin
          diff  <= d_tick - d_timer;
          prod  <= 61'(mono) * 61'(dtdm_pkg::DIV1000_MUL);
          state <= S_CLASS;
        end
        S_CLASS: begin
          flags <= (f_log   ? dtdm_pkg::FL_LOGGED : dtdm_pkg::FL_NONE)
                 | (f_drift ? dtdm_pkg::FL_DRIFT  : dtdm_pkg::FL_NONE)
                 | (f_lag   ? dtdm_pkg::FL_LAG    : dtdm_pkg::FL_NONE)
                 | (f_jump  ? dtdm_pkg::FL_JUMP   : dtdm_pkg::FL_NONE);
          state <= S_EVAL;
        end
        S_EVAL: begin
          drift_sum <= drift_sum + diff;
          if (flags[0]) begin
            wr_idx <= (wr_idx == IDX_W'(RING_DEPTH - 1)) ? '0 : wr_idx + 1'b1;
            if (fill != FILL_W'(RING_DEPTH)) begin
              fill <= fill + 1'b1;
            end
          end
          if (flags[1]) begin
            drift_events    <= drift_events + 32'd1;
            last_drift      <= diff;
            last_drift_secs <= prod[dtdm_pkg::DIV1000_SHIFT +: dtdm_pkg::SECS_W];
          end
          if (flags[2]) begin
            lag_events <= lag_events + 32'd1;
            if (lag_lo > peak_lag) begin
              peak_lag <= lag_lo;
            end
          end
          if (flags[3]) begin
            jump_events <= jump_events + 32'd1;
          end
          state <= S_EMIT;
        end
        S_READ: begin
          state <= S_RDATA;
        end
        S_RDATA: begin
          d_tick   <= ram_rdata[63:32];
          d_timer  <= ram_rdata[31:0];
          flags    <= dtdm_pkg::FL_VALID;
          res_last <= (rd_left == CNT_W'(1));
          state    <= S_EMIT;
        end
        S_EMIT: begin
          if (!res_full) begin
            if (res_last) begin
              state <= S_IDLE;
            end else begin
              rd_ptr  <= (rd_ptr == IDX_W'(RING_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
              rd_left <= rd_left - 1'b1;
              state   <= S_READ;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hdl/dual_timebase_drift_monitor_unit.sv =====
// Top level of the dual timebase drift monitor: config registers, front, back, result queue.
//
// Input channel: push/full with in_item. cmd 0 is a timebase sample, cmd 1 replays
// the delta ring oldest first. Result channel: empty/pop with result; the oldest
// result is shown while empty is low and leaves on pop.
// Configuration: cfg_we writes cfg_data to register cfg_index at the clock edge
// (0 drift threshold, 1 lag window low, 2 lag window high); other indexes are dropped.
// Write configuration only while no item is in flight.
// A sample passes the back end in these steps: delta, difference and divide-by-1000 product,
// compare, state update, result push; a seeding sample goes from delta straight to result
// push. A readout reads each ring entry through the ring's registered read port (address,
// read data, result push), and an empty ring gives one result with no ring read.
// The work queue takes up to 2 items while the back end is busy; the result
// queue holds 2 results. When the receiver stalls, the back end holds at its
// result push and the work queue fills, then full rises.
// Reset (synchronous, rst high) empties both queues, clears all counters, the
// seeded flag and the ring fill, and loads the register defaults 50, 20, 400.
module dual_timebase_drift_monitor_unit #(
  parameter int RING_DEPTH  = dtdm_pkg::RING_DEPTH_DEF,
  parameter int QUEUE_DEPTH = dtdm_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  output logic                                full,
  input  dtdm_pkg::in_item_t                  in_item,
  output logic                                empty,
  input  logic                                pop,
  output dtdm_pkg::res_item_t                 result,
  input  logic                                cfg_we,
  input  logic [dtdm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [dtdm_pkg::CFG_DATA_W-1:0]     cfg_data
);

  dtdm_pkg::cfg_t      cfg;
  dtdm_pkg::work_t     work;
  logic                work_valid;
  logic                work_pop;
  dtdm_pkg::res_item_t back_res;
  logic                back_push;
  logic                res_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.drift_event_ms <= dtdm_pkg::DRIFT_EVENT_RESET;
      cfg.lag_min_ms     <= dtdm_pkg::LAG_MIN_RESET;
      cfg.lag_max_ms     <= dtdm_pkg::LAG_MAX_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        dtdm_pkg::REG_DRIFT_EVENT: cfg.drift_event_ms <= cfg_data;
        dtdm_pkg::REG_LAG_MIN:     cfg.lag_min_ms     <= cfg_data;
        dtdm_pkg::REG_LAG_MAX:     cfg.lag_max_ms     <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  dtdm_front #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .in_item    (in_item),
    .full       (full),
    .work       (work),
    .work_valid (work_valid),
    .work_pop   (work_pop)
  );

  dtdm_back #(
    .RING_DEPTH (RING_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .work       (work),
    .work_valid (work_valid),
    .work_pop   (work_pop),
    .res        (back_res),
    .res_push   (back_push),
    .res_full   (res_full)
  );

  dtdm_fifo #(
    .WIDTH ($bits(dtdm_pkg::res_item_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_result_q (
    .clk   (clk),
    .rst   (rst),
    .push  (back_push),
    .din   (back_res),
    .full  (res_full),
    .pop   (pop),
    .dout  (result),
    .empty (empty)
  );

`ifndef SYNTHESIS
  a_push_room: assert property (@(posedge clk) disable iff (rst) back_push |-> !res_full)
    else $error("result pushed into a full queue");
  a_pop_valid: assert property (@(posedge clk) disable iff (rst) work_pop |-> work_valid)
    else $error("work taken from an empty queue");
  a_reset_clear: assert property (@(posedge clk) rst |=> empty && !full)
    else $error("queues not clear after reset");
`endif

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench of the drift monitor: queued timebase samples, ring readouts, settings.
module tb_top;
  import dtdm_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam longint RUN_LIMIT = 6_000_000;
  localparam int DRAIN_CYCLES = 20;
  localparam int LOG_DEPTH = 16;
  localparam int SHOW_LIMIT = 10;

  typedef enum int {SK_QUIET, SK_LOGGED, SK_DRIFT, SK_LAG, SK_JUMP} sample_kind_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  in_item_t in_item = '0;
  logic empty;
  logic pop = 1'b0;
  res_item_t result;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  logic [15:0] thr_ms = DRIFT_EVENT_RESET;
  logic [15:0] win_lo = LAG_MIN_RESET;
  logic [15:0] win_hi = LAG_MAX_RESET;
  logic seen_first = 1'b0;
  logic [31:0] tick_prev = '0, timer_prev = '0, sum_drift = '0, drift_last = '0;
  logic [31:0] n_drift = '0, n_lag = '0, n_jump = '0;
  logic [SECS_W-1:0] drift_secs = '0;
  logic [15:0] lag_peak = '0;
  logic [31:0] log_tick [LOG_DEPTH];
  logic [31:0] log_timer [LOG_DEPTH];
  logic [3:0] log_wr = '0;
  int log_count = 0;
  res_item_t reports_due[$];

  logic [31:0] cur_tick = '0, cur_timer = '0, cur_mono = '0;
  int hold_request = 0;
  int rx_stall_pct = 25;
  bit tx_idle_on = 1'b1;
  int fail_count = 0;
  int shown = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  dual_timebase_drift_monitor_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .in_item   (in_item),
    .empty     (empty),
    .pop       (pop),
    .result    (result),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  function automatic res_item_t snapshot(logic [5:0] flags, logic [31:0] dtick,
                                         logic [31:0] dtimer, logic is_last);
    res_item_t r;
    r.event_flags       = flags;
    r.drift_sum_ms      = sum_drift;
    r.drift_event_count = n_drift;
    r.lag_event_count   = n_lag;
    r.stall_max_out_ms  = lag_peak;
    r.jump_event_count  = n_jump;
    r.last_drift_out_ms = drift_last;
    r.last_drift_time_s = drift_secs;
    r.raw_tick_delta    = dtick;
    r.raw_timer_delta   = dtimer;
    r.last              = is_last;
    return r;
  endfunction

  function automatic void compute_reports(in_item_t it);
    logic [31:0] dt, dm, df, dl;
    logic [5:0] fl;
    longint sdt, sdm, sdf, slg, thr, half;
    int n, idx;
    if (it.cmd == OP_READOUT) begin
      n = log_count;
      if (n == 0) reports_due.push_back(snapshot(FL_NONE, '0, '0, 1'b1));
      for (int i = 0; i < n; i++) begin
        idx = (int'(log_wr) + LOG_DEPTH - n + i) % LOG_DEPTH;
        reports_due.push_back(snapshot(FL_VALID, log_tick[idx], log_timer[idx], i == n - 1));
      end
      return;
    end
    if (!seen_first) begin
      seen_first = 1'b1;
      tick_prev = it.tick_count_ms;
      timer_prev = it.timer_count_ms;
      reports_due.push_back(snapshot(FL_SEED, '0, '0, 1'b1));
      return;
    end
    dt = it.tick_count_ms - tick_prev;
    dm = it.timer_count_ms - timer_prev;
    tick_prev = it.tick_count_ms;
    timer_prev = it.timer_count_ms;
    df = dt - dm;
    dl = dm - dt;
    sum_drift += df;
    sdt = longint'($signed(dt));
    sdm = longint'($signed(dm));
    sdf = longint'($signed(df));
    slg = longint'($signed(dl));
    thr = longint'(thr_ms);
    half = thr / 2;
    fl = FL_NONE;
    if (sdf > half || sdf < -half) begin
      log_tick[log_wr] = dt;
      log_timer[log_wr] = dm;
      log_wr = log_wr + 4'd1;
      if (log_count < LOG_DEPTH) log_count++;
      fl |= FL_LOGGED;
    end
    if (sdf > thr || sdf < -thr) begin
      n_drift++;
      drift_last = df;
      drift_secs = SECS_W'(it.mono_time_ms / 1000);
      fl |= FL_DRIFT;
    end
    if (sdt >= 0 && sdm > 0) begin
      if (slg >= longint'(win_lo) && slg <= longint'(win_hi)) begin
        n_lag++;
        if (slg > longint'(lag_peak)) lag_peak = slg[15:0];
        fl |= FL_LAG;
      end else if (slg > longint'(win_hi)) begin
        n_jump++;
        fl |= FL_JUMP;
      end
    end
    reports_due.push_back(snapshot(fl, dt, dm, 1'b1));
  endfunction

  task automatic report_failure(string what, res_item_t want, res_item_t got);
    fail_count++;
    if (shown < SHOW_LIMIT) begin
      shown++;
      $display("%0t mismatch: %s\n  expected %h\n  actual   %h", $time, what, want, got);
    end
  endtask

  always @(posedge clk) begin : check_results
    res_item_t want;
    string bad;
    if (!rst && pop && !empty) begin
      if (reports_due.size() == 0) begin
        report_failure("result with nothing pending", '0, result);
      end else begin
        want = reports_due.pop_front();
        bad = "";
        if (result.event_flags !== want.event_flags) bad = {bad, " event_flags"};
        if (result.drift_sum_ms !== want.drift_sum_ms) bad = {bad, " drift_sum_ms"};
        if (result.drift_event_count !== want.drift_event_count) bad = {bad, " drift_event_count"};
        if (result.lag_event_count !== want.lag_event_count) bad = {bad, " lag_event_count"};
        if (result.stall_max_out_ms !== want.stall_max_out_ms) bad = {bad, " stall_max_out_ms"};
        if (result.jump_event_count !== want.jump_event_count) bad = {bad, " jump_event_count"};
        if (result.last_drift_out_ms !== want.last_drift_out_ms) bad = {bad, " last_drift_out_ms"};
        if (result.last_drift_time_s !== want.last_drift_time_s) bad = {bad, " last_drift_time_s"};
        if (result.raw_tick_delta !== want.raw_tick_delta) bad = {bad, " raw_tick_delta"};
        if (result.raw_timer_delta !== want.raw_timer_delta) bad = {bad, " raw_timer_delta"};
        if (result.last !== want.last) bad = {bad, " last"};
        if (bad != "") report_failure({"field", bad}, want, result);
      end
    end
  end

  initial begin : result_receiver
    int hold;
    hold = 0;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        hold = hold_request;
        hold_request = 0;
      end
      if (rst || hold > 0) begin
        pop <= 1'b0;
        if (hold > 0) hold--;
      end else if (rx_stall_pct > 0 && $urandom_range(99, 0) < 2) begin
        pop <= 1'b0;
        hold = $urandom_range(30, 8);
      end else begin
        pop <= ($urandom_range(99, 0) >= rx_stall_pct);
      end
    end
  end

  function automatic int pick_gap();
    int r;
    if (!tx_idle_on) return 0;
    r = $urandom_range(99, 0);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(25, 6);
  endfunction

  function automatic in_item_t pack_item(op_t op, logic [31:0] tick, timer, mono);
    in_item_t it;
    it.cmd = op;
    it.tick_count_ms = tick;
    it.timer_count_ms = timer;
    it.mono_time_ms = mono;
    return it;
  endfunction

  function automatic in_item_t make_sample(sample_kind_t kind);
    int p, half, mag, dif, dtimer;
    half = int'(thr_ms) / 2;
    p = $urandom_range(300, 1);
    case (kind)
      SK_QUIET:  mag = $urandom_range(half, 0);
      SK_LOGGED: mag = $urandom_range(int'(thr_ms) > half ? int'(thr_ms) : half + 1, half + 1);
      SK_DRIFT:  mag = int'(thr_ms) + $urandom_range(2000, 1);
      SK_LAG:    mag = (win_lo <= win_hi) ? $urandom_range(win_hi, win_lo)
                                          : $urandom_range(65535, 0);
      default:   mag = int'(win_hi) + $urandom_range(5000, 1);
    endcase
    dif = (kind == SK_LAG || kind == SK_JUMP || $urandom_range(1, 0) == 0) ? -mag : mag;
    dtimer = p + (dif < 0 ? -dif : 0);
    cur_timer += 32'(dtimer);
    cur_tick += 32'(dtimer + dif);
    cur_mono = ($urandom_range(9, 0) == 0) ? $urandom : cur_mono + 32'(dtimer);
    return pack_item(OP_SAMPLE, cur_tick, cur_timer, cur_mono);
  endfunction

  function automatic in_item_t random_item();
    in_item_t it;
    int r;
    r = $urandom_range(99, 0);
    it = pack_item(OP_SAMPLE, $urandom, $urandom, $urandom);
    if (r < 10) begin
      it.cmd = OP_READOUT;
    end else if (r < 18) begin
      cur_tick = it.tick_count_ms;
      cur_timer = it.timer_count_ms;
      cur_mono = it.mono_time_ms;
    end else begin
      it = make_sample(sample_kind_t'($urandom_range(SK_JUMP, SK_QUIET)));
    end
    return it;
  endfunction

  task automatic offer(in_item_t it);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    push <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (full);
    compute_reports(it);
    @(negedge clk);
  endtask

  task automatic offer_step(logic [31:0] dtick, dtimer);
    cur_tick += dtick;
    cur_timer += dtimer;
    cur_mono += dtimer;
    offer(pack_item(OP_SAMPLE, cur_tick, cur_timer, cur_mono));
  endtask

  task automatic settle();
    push <= 1'b0;
    do @(negedge clk); while (reports_due.size() != 0);
  endtask

  task automatic load_config(logic [15:0] thr, lo, hi);
    cfg_we <= 1'b1;
    cfg_index <= REG_DRIFT_EVENT;
    cfg_data <= thr;
    @(negedge clk);
    cfg_index <= REG_LAG_MIN;
    cfg_data <= lo;
    @(negedge clk);
    cfg_index <= REG_LAG_MAX;
    cfg_data <= hi;
    @(negedge clk);
    cfg_index <= REG_SPARE;
    cfg_data <= CFG_DATA_W'($urandom);
    @(negedge clk);
    cfg_we <= 1'b0;
    thr_ms = thr;
    win_lo = lo;
    win_hi = hi;
  endtask

  task automatic test_empty_readout();
    offer(pack_item(OP_READOUT, '1, '1, '1));
    offer(pack_item(OP_READOUT, '0, '0, '0));
  endtask

  task automatic test_seeding();
    cur_tick = '1;
    cur_timer = '0;
    cur_mono = '1;
    offer(pack_item(OP_SAMPLE, cur_tick, cur_timer, cur_mono));
    offer(pack_item(OP_READOUT, $urandom, $urandom, $urandom));
  endtask

  task automatic test_sample_cases();
    offer_step(100, 100);
    offer_step(130, 100);
    offer_step(125, 100);
    offer_step(150, 100);
    cur_mono = 32'hFFFF_FFFF - 32'd100;
    offer_step(151, 100);
    offer_step(100, 120);
    offer_step(100, 126);
    offer_step(100, 500);
    offer_step(100, 501);
    offer_step(100, 119);
    offer_step(10, 0);
    offer_step(-1000, 10);
    cur_mono = 32'hFFFF_FFF6;
    offer_step(0, 10);
    cur_tick = '0;
    cur_timer = '1;
    offer(pack_item(OP_SAMPLE, cur_tick, cur_timer, cur_mono));
    offer(pack_item(OP_READOUT, '0, '1, '0));
  endtask

  task automatic test_ring_overflow();
    repeat (20) offer(make_sample(SK_DRIFT));
    offer(pack_item(OP_READOUT, $urandom, $urandom, $urandom));
    offer(pack_item(OP_READOUT, $urandom, $urandom, $urandom));
  endtask

  task automatic test_backpressure();
    settle();
    hold_request = 80;
    tx_idle_on = 1'b0;
    repeat (24) offer(random_item());
    settle();
    tx_idle_on = 1'b1;
  endtask

  task automatic test_settings();
    for (int ph = 0; ph < 6; ph++) begin
      settle();
      case (ph)
        0: load_config(DRIFT_EVENT_RESET, LAG_MIN_RESET, LAG_MAX_RESET);
        1: load_config('0, '0, '0);
        2: load_config('1, '1, '0);
        3: load_config(16'd1, '0, '1);
        4: load_config(16'($urandom_range(2000, 1)), 16'($urandom_range(100, 0)),
                       16'($urandom_range(3000, 100)));
        default: load_config(16'($urandom), 16'($urandom), 16'($urandom));
      endcase
      tx_idle_on = (ph % 2 == 0);
      rx_stall_pct = (ph % 2 == 1) ? 0 : (ph == 4 ? 60 : 25);
      for (int i = 0; i < 28; i++) begin
        if (i == 14) settle();
        offer(random_item());
      end
    end
    tx_idle_on = 1'b1;
    rx_stall_pct = 25;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_empty_readout();
    test_seeding();
    test_sample_cases();
    test_ring_overflow();
    test_backpressure();
    test_settings();
    settle();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("dual_timebase_drift_monitor_unit verification clean");
    end else begin
      $display("dual_timebase_drift_monitor_unit verification failed");
    end
    $finish;
  end

  initial begin
    #RUN_LIMIT;
    $display("dual_timebase_drift_monitor_unit verification failed");
    $finish;
  end

endmodule

// ===== files.f =====
hdl/dtdm_pkg.sv
hdl/dtdm_ram.sv
hdl/dtdm_fifo.sv
hdl/dtdm_front.sv
hdl/dtdm_back.sv
hdl/dual_timebase_drift_monitor_unit.sv
tb/sv/tb_top.sv
